/* sv/sha1md_pkg.sv */
// Types and constants shared by the SHA-1 digest block.
// Used by sha1md_core and sha1_message_digest; depends on nothing else.
package sha1md_pkg;

	// Input transaction: one optional message byte and an end mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	// Output transaction: one digest word.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PAD,
		ST_HASH,
		ST_OUT
	} state_t;

	typedef logic [4:0][31:0] chain_t;

	// Index 0 (H0) sits in the low word of the packed array.
	localparam chain_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [6:0] ADD_STEP  = 7'd80;
	localparam logic [2:0] LAST_IDX  = 3'd4;

	// Sequencer requests to the compression core.
	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       restart;
	} ctrl_t;

	// Core status back to the sequencer.
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [5:0] pos;
		chain_t     chain;
	} stat_t;

endpackage

/* sv/sha1md_core.sv */
// SHA-1 compression core: byte packing, 16-word schedule window and one
// shared round unit stepped 80 times per block. Depends on sha1md_pkg.
module sha1md_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::ctrl_t  ctrl,
	output sha1md_pkg::stat_t  stat
);

	sha1md_pkg::chain_t chain_q;
	logic [31:0]        win_q [16];
	logic [23:0]        acc_q;
	logic [5:0]         pos_q;
	logic               busy_q;
	logic [6:0]         rnd_q;
	logic [31:0]        a_q, b_q, c_q, d_q, e_q;

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] w_new;
	logic [31:0] t_val;
	logic [31:0] w_mix;
	logic        round_en;
	logic        done;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1md_pkg::K_R0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_R1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1md_pkg::K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_R3;
		end
	end

	// The window head is W[t]; the word shifted in is W[t+16].
	assign w_mix    = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_new    = {w_mix[30:0], w_mix[31]};
	assign t_val    = {a_q[26:0], a_q[31:27]} + f_val + e_q + win_q[0] + k_val;
	assign round_en = busy_q && (rnd_q != sha1md_pkg::ADD_STEP);
	assign done     = busy_q && (rnd_q == sha1md_pkg::ADD_STEP);

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (pos_q[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[15] <= {acc_q, ctrl.push_byte};
			end else begin
				acc_q <= {acc_q[15:0], ctrl.push_byte};
			end
		end else if (round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
		end

		if (ctrl.push && (pos_q == sha1md_pkg::LAST_POS)) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (round_en) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha1md_pkg::INIT_CHAIN;
			pos_q   <= '0;
			busy_q  <= 1'b0;
			rnd_q   <= '0;
		end else begin
			if (ctrl.push) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == sha1md_pkg::LAST_POS) begin
					busy_q <= 1'b1;
					rnd_q  <= '0;
				end
			end
			if (round_en) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (done) begin
				busy_q     <= 1'b0;
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (ctrl.restart) begin
				chain_q <= sha1md_pkg::INIT_CHAIN;
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = done;
	assign stat.pos   = pos_q;
	assign stat.chain = chain_q;

endmodule

/* sv/sha1_message_digest.sv */
// SHA-1 message digest over a byte stream: sequencer, length counter,
// padding and digest output. Depends on sha1md_pkg and sha1md_core.
//
//   channel | direction | handshake            | payload
//   msg     | in        | msg_valid, msg_stall | msg_t: data_byte, has_byte, end_of_message
//   dig     | out       | dig_valid, dig_stall | dig_t: digest_word, word_index, last_word
//
// A transaction without a block boundary leaves the sequencer loading; the one that fills a
// 64-byte block hands it to the shared round unit (80 rounds, one add).
// An end mark adds padding bytes up to the end of each padding block (two blocks at
// most), each block followed by its rounds and the add, then five digest words.
// Reset loads the SHA-1 initial chain and clears the bit length.
// msg_stall is high while padding, hashing or emitting; dig_stall holds a word.
module sha1_message_digest (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sha1md_pkg::msg_t  msg,
	output logic              dig_valid,
	input  logic              dig_stall,
	output sha1md_pkg::dig_t  dig
);

	sha1md_pkg::state_t state_q, state_d;
	sha1md_pkg::ctrl_t  ctrl;
	sha1md_pkg::stat_t  stat;

	logic [63:0] len_q;
	logic        pad_q;
	logic        padded_q;
	logic        two_q;
	logic        fin_q;
	logic [2:0]  wi_q;

	logic        msg_acc;
	logic        dig_acc;
	logic [5:0]  pos_next;
	logic [63:0] len_sh;
	logic [7:0]  pad_byte;

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	assign msg_acc  = msg_valid && !msg_stall;
	assign dig_acc  = dig_valid && !dig_stall;
	assign pos_next = stat.pos + {5'd0, msg.has_byte};
	assign len_sh   = len_q >> {~stat.pos[2:0], 3'b000};

	// The final block carries the bit length, big-endian, in its last eight bytes.
	always_comb begin
		if (!padded_q) begin
			pad_byte = sha1md_pkg::PAD_BYTE;
		end else if (two_q || (stat.pos < sha1md_pkg::LEN_POS)) begin
			pad_byte = 8'h00;
		end else begin
			pad_byte = len_sh[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1md_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		msg_stall      = 1'b1;
		dig_valid      = 1'b0;
		case (state_q)
			sha1md_pkg::ST_LOAD: begin
				msg_stall = 1'b0;
				if (msg_valid) begin
					ctrl.push      = msg.has_byte;
					ctrl.push_byte = msg.data_byte;
					if (msg.has_byte && (stat.pos == sha1md_pkg::LAST_POS)) begin
						state_d = sha1md_pkg::ST_HASH;
					end else if (msg.end_of_message) begin
						state_d = sha1md_pkg::ST_PAD;
					end
				end
			end
			sha1md_pkg::ST_PAD: begin
				ctrl.push      = 1'b1;
				ctrl.push_byte = pad_byte;
				if (stat.pos == sha1md_pkg::LAST_POS) begin
					state_d = sha1md_pkg::ST_HASH;
				end
			end
			sha1md_pkg::ST_HASH: begin
				if (stat.done) begin
					if (!pad_q) begin
						state_d = sha1md_pkg::ST_LOAD;
					end else if (fin_q) begin
						state_d = sha1md_pkg::ST_OUT;
					end else begin
						state_d = sha1md_pkg::ST_PAD;
					end
				end
			end
			sha1md_pkg::ST_OUT: begin
				dig_valid = 1'b1;
				if (!dig_stall && (wi_q == sha1md_pkg::LAST_IDX)) begin
					ctrl.restart = 1'b1;
					state_d      = sha1md_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = sha1md_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pad_q    <= 1'b0;
			padded_q <= 1'b0;
			two_q    <= 1'b0;
			fin_q    <= 1'b0;
			wi_q     <= '0;
		end else begin
			if (msg_acc) begin
				if (msg.has_byte) begin
					len_q <= len_q + 64'd8;
				end
				if (msg.end_of_message) begin
					pad_q    <= 1'b1;
					padded_q <= 1'b0;
					fin_q    <= 1'b0;
					// A pad byte at or past the length field needs an extra block.
					two_q    <= (pos_next >= sha1md_pkg::LEN_POS);
				end
			end
			if (state_q == sha1md_pkg::ST_PAD) begin
				padded_q <= 1'b1;
				if (stat.pos == sha1md_pkg::LAST_POS) begin
					fin_q <= !two_q;
					two_q <= 1'b0;
				end
			end
			if (dig_acc) begin
				if (wi_q == sha1md_pkg::LAST_IDX) begin
					wi_q  <= '0;
					len_q <= '0;
					pad_q <= 1'b0;
				end else begin
					wi_q <= wi_q + 3'd1;
				end
			end
		end
	end

	assign dig.digest_word = stat.chain[wi_q];
	assign dig.word_index  = wi_q;
	assign dig.last_word   = (wi_q == sha1md_pkg::LAST_IDX);

	// The round unit is idle whenever digest words are shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !stat.busy)
		else $error("digest shown while the round unit is busy");

	// A finished compression is seen only by the hash wait state.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == sha1md_pkg::ST_HASH))
		else $error("compression finished outside the hash state");

	// Padding always ends on a block boundary before output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1md_pkg::ST_OUT) |-> (stat.pos == 6'd0))
		else $error("digest output with a partial block");

	// After the last word the chain and the length restart.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig.last_word) |=>
			((stat.chain == sha1md_pkg::INIT_CHAIN) && (len_q == 64'd0)))
		else $error("state not re-initialized after the digest");

endmodule

/* verif/tb_sha1_message_digest.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sha1_message_digest: byte-stream SHA-1 with padding.
// Needs sha1md_pkg for the transaction types and the sha1_message_digest RTL.
module tb_sha1_message_digest;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int MAX_REPORTS   = 10;
	localparam int DIGEST_WORDS  = 5;
	localparam int LEN_FIELD_POS = 56;
	localparam int LAST_BYTE_POS = 63;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [159:0] SHA1_IV = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] ROUND_K0 = 32'h5A827999;
	localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_stall;
	sha1md_pkg::msg_t msg = '0;
	logic dig_valid;
	logic dig_stall = 1'b0;
	sha1md_pkg::dig_t dig;

	// Predictor state.
	logic [31:0]      hash_state [DIGEST_WORDS];
	logic [7:0]       byte_block [64];
	logic [63:0]      bit_count;
	sha1md_pkg::dig_t digest_queue [$];

	int msg_gap_pct = 0;
	int dig_stall_pct = 0;
	int counted_items = 0;
	int message_count = 0;
	int byte_count = 0;
	int digests_seen = 0;
	int error_count = 0;
	int cycle_count = 0;

	sha1_message_digest u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d digest words outstanding.",
				cycle_count, digest_queue.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk)
		dig_stall <= ($urandom_range(99) < dig_stall_pct);

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < DIGEST_WORDS; i++)
			hash_state[i] = SHA1_IV[159 - 32 * i -: 32];
		bit_count = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {byte_block[4 * r], byte_block[4 * r + 1],
				byte_block[4 * r + 2], byte_block[4 * r + 3]};
		for (int r = 16; r < 80; r++)
			w[r] = rotl32(w[r - 3] ^ w[r - 8] ^ w[r - 14] ^ w[r - 16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = ROUND_K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = ROUND_K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = ROUND_K2;
			end else begin
				f = b ^ c ^ d;
				k = ROUND_K3;
			end
			t = rotl32(a, 5) + f + e + w[r] + k;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	// Updates the running hash for one accepted transaction and queues the
	// five digest words when it closes a message.
	function automatic void predict_digest(input sha1md_pkg::msg_t m);
		logic [5:0]       pos;
		logic [63:0]      len;
		sha1md_pkg::dig_t word;
		if (m.has_byte) begin
			pos = bit_count[8:3];
			byte_block[pos] = m.data_byte;
			bit_count += 64'd8;
			byte_count++;
			if (pos == LAST_BYTE_POS)
				compress_block();
		end
		if (m.end_of_message) begin
			len = bit_count;
			pos = len[8:3];
			byte_block[pos] = PAD_MARK;
			for (int i = pos + 1; i < 64; i++)
				byte_block[i] = 8'h00;
			// No room left for the length field: it goes into an extra block.
			if (pos >= LEN_FIELD_POS) begin
				compress_block();
				for (int i = 0; i < LEN_FIELD_POS; i++)
					byte_block[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				byte_block[LEN_FIELD_POS + i] = len[63 - 8 * i -: 8];
			compress_block();
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				word.digest_word = hash_state[i];
				word.word_index = 3'(i);
				word.last_word = (i == DIGEST_WORDS - 1);
				digest_queue.push_back(word);
			end
			message_count++;
			restart_hash();
		end
	endfunction

	function automatic void flag_mismatch(input string what,
			input sha1md_pkg::dig_t want, input sha1md_pkg::dig_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t %s: expected word %h index %0d last %0b, got word %h index %0d last %0b",
				$time, what, want.digest_word, want.word_index, want.last_word,
				got.digest_word, got.word_index, got.last_word);
	endfunction

	// Outputs are stable from mid-cycle to the next rising edge, so the
	// transaction that completes at that edge is checked here.
	always @(negedge clk) begin
		sha1md_pkg::dig_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			digests_seen++;
			if (digest_queue.size() == 0) begin
				flag_mismatch("unexpected digest word", '0, dig);
			end else begin
				want = digest_queue.pop_front();
				if (dig.digest_word !== want.digest_word || dig.word_index !== want.word_index ||
						dig.last_word !== want.last_word)
					flag_mismatch("digest mismatch", want, dig);
			end
		end
	end

	task automatic push_msg_item(input logic [7:0] data, input logic with_byte, input logic eom);
		sha1md_pkg::msg_t m;
		m.data_byte = data;
		m.has_byte = with_byte;
		m.end_of_message = eom;
		while ($urandom_range(99) < msg_gap_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= m;
		@(negedge clk);
		while (msg_stall)
			@(negedge clk);
		@(posedge clk);
		predict_digest(m);
		if (with_byte || eom)
			counted_items++;
	endtask

	task automatic send_message(input int len, input bit end_on_byte);
		for (int i = 0; i < len; i++) begin
			// Occasional transaction with neither byte nor end mark.
			if ($urandom_range(99) < 10)
				push_msg_item(8'($urandom), 1'b0, 1'b0);
			push_msg_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0)
			push_msg_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_for_digests();
		msg_valid <= 1'b0;
		@(posedge clk);
		while (digest_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		// Empty message, with an ignored all-ones byte on the end mark.
		push_msg_item(8'hFF, 1'b0, 1'b1);
		// The classic three-byte message, closed on its last byte.
		push_msg_item(8'h61, 1'b1, 1'b0);
		push_msg_item(8'h62, 1'b1, 1'b0);
		push_msg_item(8'h63, 1'b1, 1'b1);
		// Idle transaction, then a zero byte with the end mark.
		push_msg_item(8'h00, 1'b0, 1'b0);
		push_msg_item(8'h00, 1'b1, 1'b1);
		// One all-ones byte, an idle one, then a separate end mark.
		push_msg_item(8'hFF, 1'b1, 1'b0);
		push_msg_item(8'h55, 1'b0, 1'b0);
		push_msg_item(8'hAA, 1'b0, 1'b1);
		push_msg_item(8'h80, 1'b1, 1'b0);
		push_msg_item(8'h7F, 1'b1, 1'b0);
		push_msg_item(8'h01, 1'b1, 1'b1);
		// Two empty messages back to back.
		push_msg_item(8'h00, 1'b0, 1'b1);
		push_msg_item(8'hC3, 1'b0, 1'b1);
	endtask

	task automatic test_random_messages(input int item_budget);
		int start_items;
		int pick;
		int len;
		start_items = counted_items;
		while (counted_items - start_items < item_budget) begin
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(12);
			else if (pick < 85)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(72, 57);
			send_message(len, 1'($urandom_range(1)));
		end
	endtask

	// 55 bytes leaves room for the length in the same block; 56 needs a
	// second padding block.
	task automatic test_padding_boundaries();
		send_message(55, 1'b1);
		send_message(56, 1'b0);
	endtask

	initial begin
		int drain_cycles;
		restart_hash();
		for (int i = 0; i < 64; i++)
			byte_block[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		msg_gap_pct <= 17;
		dig_stall_pct <= 62;
		test_directed_cases();
		test_random_messages(90);
		wait_for_digests();

		msg_gap_pct <= 62;
		dig_stall_pct <= 17;
		test_random_messages(90);
		wait_for_digests();

		msg_gap_pct <= 0;
		dig_stall_pct <= 0;
		test_padding_boundaries();

		msg_valid <= 1'b0;
		drain_cycles = 0;
		while (digest_queue.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (20) @(posedge clk);
		repeat (digest_queue.size())
			flag_mismatch("digest word never produced", digest_queue.pop_front(), '0);

		$display("Hashed %0d messages (%0d bytes): empty, short, block-sized and both padding cases.",
			message_count, byte_count);
		$display("Checked %0d digest words, %0d mismatches.", digests_seen, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
